>>> hw/rtl/rpbu_pkg.sv
// rpbu_pkg: shared types, operation codes and a helper for the ARGB8888 pixel blend unit.
// Depends on nothing; used by rgba_pixel_blend_unit_top.
`timescale 1ns / 1ps

package rpbu_pkg;

    localparam int unsigned PIXEL_W  = 32;
    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned NUM_CHAN = 4;
    localparam int unsigned PROD_W   = 2 * CHAN_W;
    localparam int unsigned MODE_W   = 4;
    localparam int unsigned RGB_W    = 24;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [PIXEL_W-1:0] COLOR_MASK = 32'h00ff_ffff;
    localparam logic [PIXEL_W-1:0] ALPHA_MASK = 32'hff00_0000;
    localparam logic [CHAN_W-1:0]  CH_MAX     = 8'd255;

    typedef logic [MODE_W-1:0]    t_op_mode;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_op_mode OP_COPY        = 4'd0;
    localparam t_op_mode OP_BLEND       = 4'd1;
    localparam t_op_mode OP_MOD_ALPHA   = 4'd2;
    localparam t_op_mode OP_MOD_COLOR   = 4'd3;
    localparam t_op_mode OP_CONST_ALPHA = 4'd4;
    localparam t_op_mode OP_SRC_ALPHA   = 4'd5;
    localparam t_op_mode OP_CONST_COLOR = 4'd6;
    localparam t_op_mode OP_SRC_COLOR   = 4'd7;
    localparam t_op_mode OP_INVERT      = 4'd8;
    localparam t_op_mode OP_INV_ALPHA   = 4'd9;
    localparam t_op_mode OP_SHARPEN     = 4'd10;

    localparam t_cfg_idx CFG_OP_MODE       = 2'd0;
    localparam t_cfg_idx CFG_CONST_ALPHA   = 2'd1;
    localparam t_cfg_idx CFG_CONST_RGB     = 2'd2;
    localparam t_cfg_idx CFG_SHARPEN_LEVEL = 2'd3;

    localparam t_op_mode         RST_OP_MODE       = OP_COPY;
    localparam logic [CHAN_W-1:0] RST_CONST_ALPHA   = 8'd255;
    localparam logic [RGB_W-1:0]  RST_CONST_RGB     = 24'd0;
    localparam logic [CHAN_W-1:0] RST_SHARPEN_LEVEL = 8'd128;

    // exact floor(x / 255) for any x up to 65279, which covers every product of two 8-bit values
    function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] t;
        t = {1'b0, x} + {{(PROD_W-CHAN_W+1){1'b0}}, x[PROD_W-1:CHAN_W]} + 1'b1;
        return t[PROD_W-1:CHAN_W];
    endfunction

endpackage

>>> hw/rtl/rgba_pixel_blend_unit_top.sv
// rgba_pixel_blend_unit_top: per-pixel ARGB8888 operation unit, two register stages.
// Depends on rpbu_pkg for widths, operation codes and the divide-by-255 helper.
`timescale 1ns / 1ps

// Usage
//   Input channel (i_in_valid / o_in_ready) carries one source and one destination
//   pixel per transaction; output channel (o_out_valid / i_out_ready) returns one
//   result pixel per transaction, in order.
//   Configuration: pulse i_cfg_we with i_cfg_idx and i_cfg_data; index 0 op_mode,
//   1 const_alpha, 2 const_rgb, 3 sharpen_level. Write only while the unit is idle.
//   Pipeline: input register, then result register with the channel multipliers
//   and divide-by-255 between them; o_out_valid is set when the result register loads.
//   Throughput: one transaction per cycle unless the output stalls; each of the four
//   channel lanes has one combinational 8x8 multiply pair and constant divide.
//   Reset: drops both stages, registers return to copy mode, const_alpha 255,
//   const_rgb 0, sharpen_level 128.
//   Stall: with i_out_ready low the result holds; one more transaction still enters
//   the input register, after which o_in_ready drops until the output drains.
module rgba_pixel_blend_unit_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rpbu_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rpbu_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [rpbu_pkg::PIXEL_W-1:0]        i_src_pixel,
    input  logic [rpbu_pkg::PIXEL_W-1:0]        i_dst_pixel,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [rpbu_pkg::PIXEL_W-1:0]        o_out_pixel
);

    localparam int unsigned CW = rpbu_pkg::CHAN_W;
    localparam int unsigned PW = rpbu_pkg::PROD_W;

    rpbu_pkg::t_op_mode             r_op_mode;
    logic [CW-1:0]                  r_const_alpha;
    logic [rpbu_pkg::RGB_W-1:0]     r_const_rgb;
    logic [CW-1:0]                  r_sharpen_level;

    logic                           r_in_valid;
    logic [rpbu_pkg::PIXEL_W-1:0]   r_src;
    logic [rpbu_pkg::PIXEL_W-1:0]   r_dst;
    logic                           r_out_valid;
    logic [rpbu_pkg::PIXEL_W-1:0]   r_out_pixel;
    logic [rpbu_pkg::PIXEL_W-1:0]   n_out_pixel;

    logic                           w_out_free;
    logic                           w_advance;
    logic [CW-1:0]                  w_lane [rpbu_pkg::NUM_CHAN];
    logic [CW-1:0]                  w_sa;
    logic [CW-1:0]                  w_da;

    assign w_sa        = r_src[rpbu_pkg::PIXEL_W-1 -: CW];
    assign w_da        = r_dst[rpbu_pkg::PIXEL_W-1 -: CW];
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_advance   = r_in_valid && w_out_free;
    assign o_in_ready  = !r_in_valid || w_out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_pixel = r_out_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_mode       <= rpbu_pkg::RST_OP_MODE;
            r_const_alpha   <= rpbu_pkg::RST_CONST_ALPHA;
            r_const_rgb     <= rpbu_pkg::RST_CONST_RGB;
            r_sharpen_level <= rpbu_pkg::RST_SHARPEN_LEVEL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rpbu_pkg::CFG_OP_MODE: begin
                    r_op_mode <= i_cfg_data[rpbu_pkg::MODE_W-1:0];
                end
                rpbu_pkg::CFG_CONST_ALPHA: begin
                    r_const_alpha <= i_cfg_data[CW-1:0];
                end
                rpbu_pkg::CFG_CONST_RGB: begin
                    r_const_rgb <= i_cfg_data[rpbu_pkg::RGB_W-1:0];
                end
                rpbu_pkg::CFG_SHARPEN_LEVEL: begin
                    r_sharpen_level <= i_cfg_data[CW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_src <= i_src_pixel;
            r_dst <= i_dst_pixel;
        end
    end

    // channel lanes: d*fa + s*fb, then divide by 255
    always_comb begin
        logic [CW-1:0] sk;
        logic [CW-1:0] dk;
        logic [CW-1:0] fa;
        logic [CW-1:0] fb;
        logic [PW-1:0] sum;
        for (int k = 0; k < rpbu_pkg::NUM_CHAN; k++) begin
            sk = r_src[k*CW +: CW];
            dk = r_dst[k*CW +: CW];
            if (r_op_mode == rpbu_pkg::OP_BLEND) begin
                fa = rpbu_pkg::CH_MAX - w_sa;
                fb = w_sa;
            end else if (r_op_mode == rpbu_pkg::OP_MOD_ALPHA) begin
                fa = w_sa;
                fb = '0;
            end else begin
                fa = sk;
                fb = '0;
            end
            sum = PW'(dk * fa) + PW'(sk * fb);
            w_lane[k] = rpbu_pkg::div255(sum);
        end
    end

    always_comb begin
        unique case (r_op_mode)
            rpbu_pkg::OP_COPY: begin
                n_out_pixel = r_src;
            end
            rpbu_pkg::OP_BLEND: begin
                n_out_pixel = {(w_sa > w_da) ? w_sa : w_da, w_lane[2], w_lane[1], w_lane[0]};
            end
            rpbu_pkg::OP_MOD_ALPHA, rpbu_pkg::OP_MOD_COLOR: begin
                n_out_pixel = {w_lane[3], w_lane[2], w_lane[1], w_lane[0]};
            end
            rpbu_pkg::OP_CONST_ALPHA: begin
                n_out_pixel = {r_const_alpha, r_dst[rpbu_pkg::RGB_W-1:0]};
            end
            rpbu_pkg::OP_SRC_ALPHA: begin
                n_out_pixel = (r_dst & rpbu_pkg::COLOR_MASK) | (r_src & rpbu_pkg::ALPHA_MASK);
            end
            rpbu_pkg::OP_CONST_COLOR: begin
                n_out_pixel = {w_da, r_const_rgb};
            end
            rpbu_pkg::OP_SRC_COLOR: begin
                n_out_pixel = (r_dst & rpbu_pkg::ALPHA_MASK) | (r_src & rpbu_pkg::COLOR_MASK);
            end
            rpbu_pkg::OP_INVERT: begin
                n_out_pixel = ~r_dst;
            end
            rpbu_pkg::OP_INV_ALPHA: begin
                n_out_pixel = r_dst ^ rpbu_pkg::ALPHA_MASK;
            end
            rpbu_pkg::OP_SHARPEN: begin
                n_out_pixel = {(w_da >= r_sharpen_level) ? rpbu_pkg::CH_MAX : CW'(0),
                               r_dst[rpbu_pkg::RGB_W-1:0]};
            end
            default: begin
                n_out_pixel = r_dst;
            end
        endcase
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_pixel <= n_out_pixel;
        end
    end

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while both stages are full and stalled");

    a_advance_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("transaction moved to result stage but output not valid");

    a_held_input_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_src) && $stable(r_dst)))
        else $error("held input stage lost or changed");

    a_copy_passes_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_op_mode == rpbu_pkg::OP_COPY) |=> (r_out_pixel == $past(r_src)))
        else $error("copy mode result differs from source pixel");

    a_invert_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_op_mode == rpbu_pkg::OP_INVERT) |=> (r_out_pixel == ~$past(r_dst)))
        else $error("invert mode result differs from inverted destination");

endmodule
